// File: rtl/fmr_pkg.sv
// ----------------------------------------------------------------------------
// fmr_pkg
// shared types and constants of the fuzzy membership rank unit
// ----------------------------------------------------------------------------
package fmr_pkg;

	localparam int NUM_SETS  = 8;
	localparam int SET_W     = 52;
	localparam int IDX_W     = 3;
	localparam int POS_W     = 16;
	localparam int FRAC_W    = 16;
	localparam int QUO_W     = 17;
	localparam int DEN_W     = 17;
	localparam logic [FRAC_W-1:0] ONE_Q15 = 16'd32768;

	// set pointer value after the last set, and unit steps for the pointers
	localparam logic [IDX_W:0]   SET_END = NUM_SETS[IDX_W:0];
	localparam logic [IDX_W:0]   PTR_ONE = 1;
	localparam logic [IDX_W-1:0] IDX_ONE = 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SETUP,
		ST_CLASSIFY,
		ST_DIV,
		ST_SQ,
		ST_CUBE,
		ST_BLEND,
		ST_PROD,
		ST_NEXT,
		ST_EMIT
	} state_t;

	// request to the divider
	typedef struct packed {
		logic             start;
		logic [DEN_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	// divider status
	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

// File: rtl/fuzzy_membership_rank_unit.sv
// ----------------------------------------------------------------------------
// fuzzy_membership_rank_unit
// fuzzifies one sample against eight smoothstep sets, ranks the results
// ----------------------------------------------------------------------------
// usage:
//  cfg channel writes set_0..set_7 (cfg_index, cfg_data); cfg_ready is high
//  only while idle. sample channel takes one word; results come out as
//  membership/set_index/last words, descending, ties lower index first,
//  last on the final one. no enabled set gives no output word.
// datapath: one shared 16-step serial divider and one shared 32 x 17
//  multiplier. an enabled set runs, for each of its two halves, setup,
//  classify, a division unless the ratio is clamped, square, cubic and
//  blend, then product and insert; a disabled set goes from load to next.
//  ranked words then come out at one word per cycle while out_ready is
//  high. sample ready is low from acceptance until the last result is taken.
// reset clears all set registers (no set enabled) and the sequencer.
// a stalled receiver holds the current result word; nothing is lost.
// ----------------------------------------------------------------------------
module fuzzy_membership_rank_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [51:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        membership,
	output logic [2:0]         set_index,
	output logic               last
);

	logic [fmr_pkg::SET_W-1:0]  set_q [fmr_pkg::NUM_SETS];
	fmr_pkg::state_t            state_q, state_d;
	logic signed [15:0]         x_q;
	logic [fmr_pkg::IDX_W-1:0]  set_ptr;
	logic [fmr_pkg::IDX_W:0]    ptr_q;
	logic                       half_q;  // 0 left-center, 1 center-right
	logic [fmr_pkg::FRAC_W-1:0] t_q, s_q, a_q, b_q, m_q;
	logic [31:0]                sq_q;
	logic signed [17:0]         num_q, den_q;
	fmr_pkg::div_req_t          dreq;
	fmr_pkg::div_rsp_t          drsp;
	logic [fmr_pkg::IDX_W-1:0]  rd_ptr_q;
	logic [fmr_pkg::FRAC_W-1:0] rd_mem;
	logic [fmr_pkg::IDX_W-1:0]  rd_idx;
	logic [fmr_pkg::IDX_W:0]    count;
	logic                       ins, clear;

	// current set fields
	logic [fmr_pkg::SET_W-1:0] cur;
	logic signed [17:0] e0, e1;
	logic fa, fb;
	assign set_ptr = ptr_q[fmr_pkg::IDX_W-1:0];
	assign cur = set_q[set_ptr];
	always_comb begin
		if (!half_q) begin
			e0 = 18'(signed'(cur[15:0]));
			e1 = 18'(signed'(cur[31:16])) + 18'sd1;
			fa = cur[48];
			fb = cur[49];
		end else begin
			e0 = 18'(signed'(cur[31:16]));
			e1 = 18'(signed'(cur[47:32])) + 18'sd1;
			fa = cur[49];
			fb = cur[50];
		end
	end

	// shared multiplier, 32 x 17 bits
	logic [31:0] mul_a;
	logic [16:0] mul_b;
	logic [48:0] mul_p;
	always_comb begin
		case (state_q)
			fmr_pkg::ST_SQ: begin
				mul_a = {16'd0, t_q};
				mul_b = {1'b0, t_q};
			end
			fmr_pkg::ST_CUBE: begin
				mul_a = sq_q;
				mul_b = 17'd98304 - {t_q, 1'b0};
			end
			default: begin
				mul_a = {16'd0, a_q};
				mul_b = {1'b0, b_q};
			end
		endcase
		mul_p = 49'(mul_a) * 49'(mul_b);
	end

	fmr_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	fmr_sort u_sort (
		.clk(clk), .arst_n(arst_n), .clear(clear), .ins(ins),
		.ins_mem(m_q), .ins_idx(set_ptr), .rd_ptr(rd_ptr_q),
		.rd_mem(rd_mem), .rd_idx(rd_idx), .count(count)
	);

	// set registers, written only while idle
	assign cfg_ready = (state_q == fmr_pkg::ST_IDLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < fmr_pkg::NUM_SETS; k++) set_q[k] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			set_q[cfg_index] <= cfg_data;
		end
	end

	// next state and controls
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		dreq     = '0;
		ins      = 1'b0;
		clear    = 1'b0;
		unique case (state_q)
			fmr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = fmr_pkg::ST_LOAD;
					clear   = 1'b1;
				end
			end
			fmr_pkg::ST_LOAD: begin
				if (ptr_q == fmr_pkg::SET_END) begin
					state_d = (count == '0) ? fmr_pkg::ST_IDLE : fmr_pkg::ST_EMIT;
				end else if (!cur[51]) begin
					state_d = fmr_pkg::ST_NEXT;
				end else begin
					state_d = fmr_pkg::ST_SETUP;
				end
			end
			fmr_pkg::ST_SETUP: state_d = fmr_pkg::ST_CLASSIFY;
			fmr_pkg::ST_CLASSIFY: begin
				if (den_q == 18'sd0 || num_q <= 18'sd0 || num_q >= den_q) begin
					state_d = fmr_pkg::ST_SQ;
				end else begin
					dreq.start = 1'b1;
					dreq.num   = num_q[16:0];
					dreq.den   = den_q[16:0];
					state_d    = fmr_pkg::ST_DIV;
				end
			end
			fmr_pkg::ST_DIV: begin
				if (drsp.done) state_d = fmr_pkg::ST_SQ;
			end
			fmr_pkg::ST_SQ:    state_d = fmr_pkg::ST_CUBE;
			fmr_pkg::ST_CUBE:  state_d = fmr_pkg::ST_BLEND;
			fmr_pkg::ST_BLEND: state_d = half_q ? fmr_pkg::ST_PROD : fmr_pkg::ST_SETUP;
			fmr_pkg::ST_PROD:  state_d = fmr_pkg::ST_NEXT;
			fmr_pkg::ST_NEXT: begin
				ins     = cur[51];
				state_d = fmr_pkg::ST_LOAD;
			end
			fmr_pkg::ST_EMIT: begin
				if (out_ready && last) state_d = fmr_pkg::ST_IDLE;
			end
			default: state_d = fmr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= fmr_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// edge setup for one half: sign-normalized numerator and denominator
	logic signed [17:0] n_raw, d_raw, n_abs, d_abs;
	always_comb begin
		n_raw = 18'(x_q) - e0;
		d_raw = e1 - e0;
		n_abs = d_raw[17] ? -n_raw : n_raw;
		d_abs = d_raw[17] ? -d_raw : d_raw;
	end

	// rounding of the ratio, the cubic and the product
	logic [16:0] tr;
	logic [15:0] s_next, m_next, blend;
	assign tr     = (drsp.quo + 17'd1) >> 1;
	assign s_next = 16'((mul_p + 49'd536870912) >> 30);
	assign m_next = 16'((mul_p + 49'd16384) >> 15);
	always_comb begin
		if (fa == fb) blend = fa ? fmr_pkg::ONE_Q15 : 16'd0;
		else blend = fa ? fmr_pkg::ONE_Q15 - s_q : s_q;
	end

	// sequencer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			half_q   <= 1'b0;
			rd_ptr_q <= '0;
		end else begin
			case (state_q)
				fmr_pkg::ST_IDLE: begin
					ptr_q    <= '0;
					half_q   <= 1'b0;
					rd_ptr_q <= '0;
				end
				fmr_pkg::ST_BLEND: half_q <= 1'b1;
				fmr_pkg::ST_NEXT: begin
					ptr_q  <= ptr_q + fmr_pkg::PTR_ONE;
					half_q <= 1'b0;
				end
				fmr_pkg::ST_EMIT: begin
					if (out_ready && !last) rd_ptr_q <= rd_ptr_q + fmr_pkg::IDX_ONE;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			fmr_pkg::ST_IDLE: begin
				if (in_valid) x_q <= sample;
			end
			fmr_pkg::ST_SETUP: begin
				num_q <= n_abs;
				den_q <= d_abs;
			end
			fmr_pkg::ST_CLASSIFY: begin
				if (den_q == 18'sd0) t_q <= (num_q > 18'sd0) ? fmr_pkg::ONE_Q15 : '0;
				else if (num_q <= 18'sd0) t_q <= '0;
				else if (num_q >= den_q) t_q <= fmr_pkg::ONE_Q15;
			end
			fmr_pkg::ST_DIV: begin
				if (drsp.done) t_q <= tr[15:0];
			end
			fmr_pkg::ST_SQ:   sq_q <= mul_p[31:0];
			fmr_pkg::ST_CUBE: s_q <= s_next;
			fmr_pkg::ST_BLEND: begin
				if (!half_q) a_q <= blend;
				else b_q <= blend;
			end
			fmr_pkg::ST_PROD: m_q <= m_next;
			default: ;
		endcase
	end

	assign out_valid  = (state_q == fmr_pkg::ST_EMIT);
	assign membership = rd_mem;
	assign set_index  = rd_idx;
	assign last       = (({1'b0, rd_ptr_q} + fmr_pkg::PTR_ONE) == count);

endmodule

// File: rtl/fmr_div.sv
// ----------------------------------------------------------------------------
// fmr_div
// restoring divider, one quotient bit per cycle: q = floor(num*2^16 / den)
// for num < den, used for the rounded q1.15 ratio
// ----------------------------------------------------------------------------
module fmr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  fmr_pkg::div_req_t  req,
	output fmr_pkg::div_rsp_t  rsp
);

	logic [fmr_pkg::DEN_W:0]   rem_q;
	logic [fmr_pkg::DEN_W-1:0] den_q;
	logic [fmr_pkg::QUO_W-1:0] quo_q;
	logic [4:0]                cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [fmr_pkg::DEN_W+1:0] shl;
	logic [fmr_pkg::DEN_W+1:0] dif;

	// one shift and subtract step
	always_comb begin
		shl = {rem_q, 1'b0};
		dif = shl - {2'b00, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.num};
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (!dif[fmr_pkg::DEN_W+1]) begin
				rem_q <= dif[fmr_pkg::DEN_W:0];
				quo_q <= {quo_q[fmr_pkg::QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= shl[fmr_pkg::DEN_W:0];
				quo_q <= {quo_q[fmr_pkg::QUO_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// File: rtl/fmr_sort.sv
// ----------------------------------------------------------------------------
// fmr_sort
// ranked list: insertion of one membership at a time, stable on ties,
// then read out in order
// ----------------------------------------------------------------------------
module fmr_sort (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clear,
	input  logic                       ins,
	input  logic [fmr_pkg::FRAC_W-1:0] ins_mem,
	input  logic [fmr_pkg::IDX_W-1:0]  ins_idx,
	input  logic [fmr_pkg::IDX_W-1:0]  rd_ptr,
	output logic [fmr_pkg::FRAC_W-1:0] rd_mem,
	output logic [fmr_pkg::IDX_W-1:0]  rd_idx,
	output logic [fmr_pkg::IDX_W:0]    count
);

	logic [fmr_pkg::FRAC_W-1:0] mem_q [fmr_pkg::NUM_SETS];
	logic [fmr_pkg::IDX_W-1:0]  idx_q [fmr_pkg::NUM_SETS];
	logic [fmr_pkg::IDX_W:0]    cnt_q;
	logic [fmr_pkg::NUM_SETS-1:0] gt;
	logic [fmr_pkg::NUM_SETS-1:0] gt_prev;

	// entries strictly below the new value shift down
	always_comb begin
		for (int k = 0; k < fmr_pkg::NUM_SETS; k++) begin
			gt[k] = (k < cnt_q) && (mem_q[k] < ins_mem);
		end
		gt_prev = {gt[fmr_pkg::NUM_SETS-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clear) begin
			cnt_q <= '0;
		end else if (ins) begin
			cnt_q <= cnt_q + fmr_pkg::PTR_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			for (int k = 0; k < fmr_pkg::NUM_SETS; k++) begin
				if (gt[k]) begin
					if (gt_prev[k]) begin
						mem_q[k] <= mem_q[k-1];
						idx_q[k] <= idx_q[k-1];
					end else begin
						mem_q[k] <= ins_mem;
						idx_q[k] <= ins_idx;
					end
				end else if (k == cnt_q && !gt_prev[k]) begin
					mem_q[k] <= ins_mem;
					idx_q[k] <= ins_idx;
				end else if (k == cnt_q) begin
					mem_q[k] <= mem_q[k-1];
					idx_q[k] <= idx_q[k-1];
				end
			end
		end
	end

	assign rd_mem = mem_q[rd_ptr];
	assign rd_idx = idx_q[rd_ptr];
	assign count  = cnt_q;

endmodule

// File: tb/fuzzy_membership_rank_unit_tb.sv
// ----------------------------------------------------------------------------
// fuzzy_membership_rank_unit_tb
// self-checking bench: programs the eight smoothstep sets, feeds samples and
// compares every ranked membership word against an in-bench fixed-point
// predictor, with random idling on both sides and one long output stall
// ----------------------------------------------------------------------------
module fuzzy_membership_rank_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SETS       = fmr_pkg::NUM_SETS;
	localparam int SET_W          = fmr_pkg::SET_W;
	localparam int IDX_W          = fmr_pkg::IDX_W;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 600;
	localparam int STALL_CYCLES   = 3000;

	typedef struct {
		logic [15:0] membership;
		logic [2:0]  set_index;
		logic        last;
	} rank_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index;
	logic [SET_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic signed [15:0]    sample;
	logic                  out_valid;
	logic                  out_ready;
	logic [15:0]           membership;
	logic [2:0]            set_index;
	logic                  last;

	logic [SET_W-1:0] set_regs [NUM_SETS];
	rank_word_t       ranked_q [$];
	int               fail_count = 0;
	int               idle_cycles = 0;
	bit               quiet;
	bit               stall_req;

	fuzzy_membership_rank_unit dut (.*);

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic longint unsigned smooth_frac(int e0, int e1, int x);
		longint num;
		longint den;
		longint unsigned t;
		num = longint'(x) - e0;
		den = longint'(e1) - e0;
		// reversed edges flip both sides
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		if (den == 0) t = (num > 0) ? 32768 : 0;
		else if (num <= 0) t = 0;
		else if (num >= den) t = 32768;
		else begin
			t = (longint'(num) * 65536 + den) / (2 * den);
			if (t > 32768) t = 32768;
		end
		return (t * t * (98304 - 2 * t) + (64'd1 << 29)) >> 30;
	endfunction

	function automatic longint unsigned blend(bit a, bit b, longint unsigned s);
		if (a == b) return a ? 32768 : 0;
		return a ? 32768 - s : s;
	endfunction

	function automatic logic [15:0] set_degree(logic [SET_W-1:0] r, logic signed [15:0] x);
		int lp;
		int cp;
		int rp;
		longint unsigned a;
		longint unsigned b;
		lp = int'($signed(r[15:0]));
		cp = int'($signed(r[31:16]));
		rp = int'($signed(r[47:32]));
		a = blend(r[48], r[49], smooth_frac(lp, cp + 1, int'(x)));
		b = blend(r[49], r[50], smooth_frac(cp, rp + 1, int'(x)));
		return 16'((a * b + 16384) >> 15);
	endfunction

	// rank enabled sets, stable on ties, and queue the expected words
	task automatic predict_ranking(logic signed [15:0] x);
		logic [15:0] deg [NUM_SETS];
		int          idx [NUM_SETS];
		int          cnt;
		int          j;
		logic [15:0] m;
		rank_word_t  w;
		cnt = 0;
		for (int i = 0; i < NUM_SETS; i++) begin
			if (set_regs[i][51]) begin
				m = set_degree(set_regs[i], x);
				j = cnt;
				while (j > 0 && deg[j-1] < m) begin
					deg[j] = deg[j-1];
					idx[j] = idx[j-1];
					j--;
				end
				deg[j] = m;
				idx[j] = i;
				cnt++;
			end
		end
		for (int i = 0; i < cnt; i++) begin
			w.membership = deg[i];
			w.set_index  = 3'(idx[i]);
			w.last       = (i + 1 == cnt);
			ranked_q.insert(ranked_q.size(), w);
		end
	endtask

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	task automatic send_sample(logic signed [15:0] x);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 15) @(negedge clk);
		in_valid = 1'b1;
		sample   = x;
		do @(posedge clk); while (!in_ready);
		predict_ranking(x);
		@(negedge clk);
		in_valid = 1'b0;
		sample   = 16'($urandom);
	endtask

	// registers only change while the block is idle
	task automatic wait_idle();
		while (ranked_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_set(int i, logic [SET_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = IDX_W'(i);
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		set_regs[i] = data;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [SET_W-1:0] pack_set(bit en, bit [2:0] flags,
			logic [15:0] l, logic [15:0] c, logic [15:0] r);
		return {en, flags, r, c, l};
	endfunction

	function automatic logic [15:0] near_pos();
		return 16'($urandom_range(4096) - 2048);
	endfunction

	// small-range set, usually ordered, with random flags and enable; sometimes all random bits
	function automatic logic [SET_W-1:0] random_set();
		int p [3];
		int t;
		if ($urandom_range(9) == 0) return SET_W'({$urandom, $urandom});
		for (int k = 0; k < 3; k++) p[k] = int'($signed(near_pos()));
		if ($urandom_range(4) != 0) begin
			for (int a = 0; a < 2; a++)
				for (int b = 0; b < 2 - a; b++)
					if (p[b] > p[b+1]) begin
						t = p[b];
						p[b] = p[b+1];
						p[b+1] = t;
					end
		end
		return pack_set($urandom_range(5) != 0, 3'($urandom),
			16'(p[0]), 16'(p[1]), 16'(p[2]));
	endfunction

	function automatic logic signed [15:0] random_sample();
		if ($urandom_range(3) == 0) return 16'($urandom);
		return near_pos();
	endfunction

	// ------------------------------------------------------------------
	// receiver ready and long hold-off
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		bit stall_done;
		stall_left = 0;
		stall_done = 1'b0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req && !stall_done) begin
				stall_left = STALL_CYCLES;
				stall_done = 1'b1;
			end
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = quiet || ($urandom_range(99) >= 15);
			end
		end
	end

	// result check
	always @(posedge clk) begin
		rank_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (ranked_q.size() == 0) begin
				$error("unexpected word: membership %0d set_index %0d last %0d",
					membership, set_index, last);
				fail_count++;
			end else begin
				w = ranked_q.pop_front();
				if (membership !== w.membership) begin
					$error("membership: expected %0d actual %0d", w.membership, membership);
					fail_count++;
				end
				if (set_index !== w.set_index) begin
					$error("set_index: expected %0d actual %0d", w.set_index, set_index);
					fail_count++;
				end
				if (last !== w.last) begin
					$error("last: expected %0d actual %0d", w.last, last);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("fuzzy_membership_rank_unit regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_no_sets();
		send_sample(16'sh0000);
		send_sample(16'sh7fff);
		send_sample(-16'sh8000);
		wait_idle();
	endtask

	task automatic test_directed();
		logic signed [15:0] pts [8] = '{-16'sh8000, 16'sh7fff, 16'sh0000, -16'sh0100,
			16'sh0100, 16'sh0080, 16'sh0001, -16'sh0001};
		// triangles, shoulders, reversed and coincident edges, extremes
		write_set(0, pack_set(1, 3'b010, -16'sh0100, 16'sh0000, 16'sh0100));
		write_set(1, pack_set(1, 3'b011, -16'sh0200, 16'sh0000, 16'sh0200));
		write_set(2, pack_set(1, 3'b110, -16'sh0100, 16'sh0000, 16'sh0100));
		write_set(3, pack_set(1, 3'b101, 16'sh0100, 16'sh0000, -16'sh0100));
		write_set(4, pack_set(1, 3'b010, 16'sh0000, 16'sh0000, 16'sh0000));
		write_set(5, pack_set(1, 3'b010, -16'sh8000, 16'sh7fff, 16'sh7fff));
		write_set(6, pack_set(1, 3'b111, 16'sh0000, 16'sh0000, 16'sh0000));
		write_set(7, pack_set(1, 3'b010, -16'sh0100, 16'sh0000, 16'sh0100));
		foreach (pts[k]) send_sample(pts[k]);
		wait_idle();
		// all bits set in every field, then all clear but enabled
		for (int i = 0; i < NUM_SETS; i++) write_set(i, {SET_W{1'b1}});
		send_sample(16'sh7fff);
		send_sample(-16'sh8000);
		wait_idle();
		for (int i = 0; i < NUM_SETS; i++)
			write_set(i, pack_set(1, 3'b000, 16'h0000, 16'h0000, 16'h0000));
		send_sample(16'sh0000);
		send_sample(16'sh0001);
		wait_idle();
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 9; phase++) begin
			for (int i = 0; i < NUM_SETS; i++) write_set(i, random_set());
			quiet = (phase == 4);
			for (int n = 0; n < 50; n++) send_sample(random_sample());
			wait_idle();
		end
		quiet = 1'b0;
	endtask

	task automatic test_backpressure();
		for (int i = 0; i < NUM_SETS; i++) write_set(i, random_set() | (52'd1 << 51));
		@(negedge clk);
		stall_req = 1'b1;
		for (int n = 0; n < 6; n++) send_sample(random_sample());
		wait_idle();
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		sample      = '0;
		quiet       = 1'b0;
		stall_req   = 1'b0;
		foreach (set_regs[i]) set_regs[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_no_sets();
		test_directed();
		test_random();
		test_backpressure();

		if (fail_count == 0)
			$display("fuzzy_membership_rank_unit regression: pass");
		else
			$display("fuzzy_membership_rank_unit regression: fail");
		$finish;
	end

endmodule
